/* design/csd_sas_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// csd_sas_pkg
// Shared types, codes and field widths of the CSD shift-add sequencer.
// -----------------------------------------------------------------------------
package csd_sas_pkg;

   localparam int DEF_WINDOW_DIGITS = 3;
   localparam int DEF_MAX_DIGITS    = 32;

   // fixed field widths of a request
   localparam int DIGITS_W    = 64;
   localparam int COUNT_W     = 6;
   localparam int SIZE_W      = 2;
   localparam int SRC_CODE_W  = 4;
   localparam int REG_NUM_W   = 4;
   localparam int DST_CODE_W  = 3;
   localparam int DIG_IDX_W   = 5;   // 32 digit slots in the digit word
   localparam int WIN_OFS_W   = 4;   // offset inside a window of up to 16 digits

   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USED_W  = 25;

   localparam logic [1:0] DIGIT_ZERO = 2'b00;
   localparam logic [1:0] DIGIT_PLUS = 2'b01;

   localparam logic [1:0] OP_PASS = 2'd0;
   localparam logic [1:0] OP_INV  = 2'd1;
   localparam logic [1:0] OP_ADD  = 2'd2;
   localparam logic [1:0] OP_SUB  = 2'd3;

   localparam logic [1:0] SRC_MOVED = 2'd0;
   localparam logic [1:0] SRC_ACC   = 2'd1;
   localparam logic [1:0] SRC_ZERO  = 2'd2;

   localparam logic [DST_CODE_W-1:0] DST_ACC        = 3'd0;
   localparam logic [DST_CODE_W-1:0] DST_VEC_FIRST  = 3'd3;
   localparam logic [DST_CODE_W-1:0] DST_VEC_LAST   = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_SEARCH,
      ST_GEN,
      ST_WRITE
   } state_type;

   typedef enum logic [1:0] {
      EMIT_FIRST,
      EMIT_ZERO,
      EMIT_ACCUM,
      EMIT_WRITE
   } emit_kind_type;

   // controller to datapath
   typedef struct packed {
      logic          load;
      logic          step;
      logic          emit;
      emit_kind_type kind;
      logic          last;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic found;
      logic digit_lt_len;
      logic window_ge_len;
      logic dst_nonzero;
      logic out_free;
   } sts_type;

endpackage

/* design/csd_sas_ctrl.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// csd_sas_ctrl
// Sequencing state machine: first-digit search, window walk and final write.
// -----------------------------------------------------------------------------
module csd_sas_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  csd_sas_pkg::sts_type sts,
   output csd_sas_pkg::ctl_type ctl
);
   import csd_sas_pkg::*;

   state_type state_ff, state_in;
   logic      step;
   logic      gen_more;

   assign req_tready = (state_ff == ST_IDLE);
   assign step       = (state_ff != ST_IDLE) && sts.out_free;
   assign gen_more   = sts.found ? sts.digit_lt_len : !sts.window_ge_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_FIRST;
         end
         ST_FIRST: begin
            if (step) state_in = sts.found ? ST_GEN : ST_SEARCH;
         end
         ST_SEARCH: begin
            if (step) begin
               if (sts.found) begin
                  if (sts.digit_lt_len)    state_in = ST_GEN;
                  else if (sts.dst_nonzero) state_in = ST_WRITE;
                  else                      state_in = ST_IDLE;
               end else if (sts.window_ge_len) begin
                  state_in = sts.dst_nonzero ? ST_WRITE : ST_IDLE;
               end
            end
         end
         ST_GEN: begin
            if (step && !gen_more) state_in = sts.dst_nonzero ? ST_WRITE : ST_IDLE;
         end
         ST_WRITE: begin
            if (step) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl.load = req_tvalid && req_tready;
      ctl.step = step;
      ctl.emit = 1'b0;
      ctl.kind = EMIT_ACCUM;
      ctl.last = 1'b0;
      case (state_ff)
         ST_FIRST: begin
            ctl.emit = sts.found;
            ctl.kind = EMIT_FIRST;
         end
         ST_SEARCH: begin
            if (sts.found) begin
               ctl.emit = 1'b1;
               ctl.kind = EMIT_FIRST;
               ctl.last = !sts.digit_lt_len && !sts.dst_nonzero;
            end else begin
               ctl.emit = sts.window_ge_len;
               ctl.kind = EMIT_ZERO;
               ctl.last = !sts.dst_nonzero;
            end
         end
         ST_GEN: begin
            ctl.emit = 1'b1;
            ctl.kind = EMIT_ACCUM;
            ctl.last = !gen_more && !sts.dst_nonzero;
         end
         ST_WRITE: begin
            ctl.emit = 1'b1;
            ctl.kind = EMIT_WRITE;
            ctl.last = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

/* design/csd_sas_dpath.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// csd_sas_dpath
// Request registers, digit position, window scan and command output register.
// -----------------------------------------------------------------------------
module csd_sas_dpath #(
   parameter int WINDOW_DIGITS = csd_sas_pkg::DEF_WINDOW_DIGITS,
   parameter int MAX_DIGITS    = csd_sas_pkg::DEF_MAX_DIGITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [csd_sas_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [csd_sas_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                               rsp_tlast,
   input  csd_sas_pkg::ctl_type               ctl,
   output csd_sas_pkg::sts_type               sts
);
   import csd_sas_pkg::*;

   localparam int PosW = $clog2(MAX_DIGITS + 3 * WINDOW_DIGITS);
   localparam int CmpW = (PosW > COUNT_W) ? PosW : COUNT_W;

   logic [DIGITS_W-1:0]   digits_ff;
   logic [COUNT_W-1:0]    len_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [SRC_CODE_W-1:0] src_code_ff;
   logic [REG_NUM_W-1:0]  src_num_ff;
   logic [DST_CODE_W-1:0] dst_code_ff;
   logic [REG_NUM_W-1:0]  dst_num_ff;
   logic [PosW-1:0]       pos_ff, pos_in;

   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff;
   logic                  rsp_valid_ff;

   logic [COUNT_W-1:0]    req_count;
   logic [COUNT_W-1:0]    req_len;
   logic                  found;
   logic [WIN_OFS_W-1:0]  f_idx;
   logic [1:0]            f_digit;
   logic [PosW-1:0]       pos_digit;
   logic [PosW-1:0]       pos_window;
   logic [CmpW-1:0]       rem;
   logic                  dst_vec;

   logic [1:0]            c_op;
   logic [1:0]            c_shift;
   logic [1:0]            c_src;
   logic [DST_CODE_W-1:0] c_dst;
   logic                  c_mv;
   logic                  c_from_unit;
   logic [SRC_CODE_W-1:0] c_msrc;
   logic [REG_NUM_W-1:0]  c_msrc_num;
   logic [REG_NUM_W-1:0]  c_mdst_num;

   assign req_count = req_tdata[69:64];
   assign req_len   = (req_count > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS) : req_count;

   // first nonzero digit of the window at pos; digits at or past the count read zero
   always_comb begin
      logic [PosW-1:0]      k;
      logic [DIG_IDX_W-1:0] kidx;
      logic [1:0]           d;
      found   = 1'b0;
      f_idx   = '0;
      f_digit = DIGIT_ZERO;
      for (int i = WINDOW_DIGITS - 1; i >= 0; i--) begin
         k    = pos_ff + PosW'(i);
         kidx = DIG_IDX_W'(k);
         d    = (CmpW'(k) < CmpW'(len_ff)) ? digits_ff[{kidx, 1'b0} +: 2] : DIGIT_ZERO;
         if (d != DIGIT_ZERO) begin
            found   = 1'b1;
            f_idx   = WIN_OFS_W'(i);
            f_digit = d;
         end
      end
   end

   assign pos_digit  = pos_ff + PosW'(f_idx) + PosW'(1);
   assign pos_window = pos_ff + PosW'(WINDOW_DIGITS);

   always_comb begin
      rem = (CmpW'(pos_ff) < CmpW'(len_ff)) ? CmpW'(len_ff) - CmpW'(pos_ff) : '0;
      if (rem > CmpW'(WINDOW_DIGITS)) rem = CmpW'(WINDOW_DIGITS);
   end

   assign dst_vec = dst_code_ff inside {[DST_VEC_FIRST:DST_VEC_LAST]};

   assign sts.found         = found;
   assign sts.digit_lt_len  = CmpW'(pos_digit) < CmpW'(len_ff);
   assign sts.window_ge_len = CmpW'(pos_window) >= CmpW'(len_ff);
   assign sts.dst_nonzero   = (dst_code_ff != DST_ACC);
   assign sts.out_free      = !rsp_valid_ff || rsp_tready;

   // command fields
   always_comb begin
      c_op        = OP_PASS;
      c_shift     = 2'd0;
      c_src       = SRC_ACC;
      c_dst       = DST_ACC;
      c_mv        = 1'b0;
      c_from_unit = 1'b0;
      c_msrc      = '0;
      c_msrc_num  = '0;
      c_mdst_num  = '0;
      case (ctl.kind)
         EMIT_FIRST: begin
            c_op       = (f_digit == DIGIT_PLUS) ? OP_PASS : OP_INV;
            c_src      = SRC_MOVED;
            c_mv       = 1'b1;
            c_msrc     = src_code_ff;
            c_msrc_num = src_num_ff;
         end
         EMIT_ZERO: begin
            c_src = SRC_ZERO;
         end
         EMIT_ACCUM: begin
            if (found) begin
               c_op    = (f_digit == DIGIT_PLUS) ? OP_ADD : OP_SUB;
               c_shift = 2'(f_idx + WIN_OFS_W'(1));
            end else begin
               c_shift = rem[1:0];
            end
         end
         EMIT_WRITE: begin
            c_dst       = dst_code_ff;
            c_mv        = dst_vec;
            c_from_unit = dst_vec;
            c_mdst_num  = dst_num_ff;
         end
         default: ;
      endcase
      rsp_data_in = {(RSP_DATA_W - RSP_USED_W)'(0), c_mdst_num, c_msrc_num, c_msrc,
                     c_from_unit, c_mv, size_ff, c_dst, c_src, c_shift, c_op};
   end

   always_comb begin
      pos_in = pos_ff;
      if (ctl.load)      pos_in = '0;
      else if (ctl.step) pos_in = found ? pos_digit : pos_window;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (ctl.step && ctl.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)      rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         digits_ff   <= req_tdata[63:0];
         len_ff      <= req_len;
         size_ff     <= req_tdata[71:70];
         src_code_ff <= req_tdata[75:72];
         src_num_ff  <= req_tdata[79:76];
         dst_code_ff <= req_tdata[82:80];
         dst_num_ff  <= req_tdata[86:83];
      end
      if (ctl.step && ctl.emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= ctl.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* design/csd_shift_add_sequencer.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// csd_shift_add_sequencer
// Turns one CSD multiply request into its run of shift-add commands.
// -----------------------------------------------------------------------------
// Order: the request transaction moves the state machine out of idle, and the first
// command is registered on the step that finds the first nonzero digit, after one step
// for each all-zero window scanned before it. Throughput: one step per cycle; a step
// stops at the next nonzero digit or covers a window. A new request is taken only once
// the step that registers the run's last command has returned the state machine to
// idle. Output stalls hold the steps. Reset clears the state machine, digit position and output valid; no sweep.
module csd_shift_add_sequencer #(
   parameter int WINDOW_DIGITS = csd_sas_pkg::DEF_WINDOW_DIGITS,
   parameter int MAX_DIGITS    = csd_sas_pkg::DEF_MAX_DIGITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // digits[63:0], digit_count[69:64], elem_size[71:70], src_code[75:72],
   // src_num[79:76], dst_code[82:80], dst_num[86:83], zero[87]
   input  logic [csd_sas_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // sa_op[1:0], sa_shamt[3:2], sa_src[5:4], sa_dst[8:6], sa_size[10:9],
   // mov_en[11], mov_from_unit[12], mov_src[16:13], mov_src_num[20:17],
   // mov_dst_num[24:21], zero[31:25]
   output logic [csd_sas_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                               rsp_tlast
);
   import csd_sas_pkg::*;

   ctl_type ctl;
   sts_type sts;

   csd_sas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   csd_sas_dpath #(
      .WINDOW_DIGITS (WINDOW_DIGITS),
      .MAX_DIGITS    (MAX_DIGITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .ctl        (ctl),
      .sts        (sts)
   );

endmodule

/* design/csd_sas_checker.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// csd_sas_checker
// Port-level assertions of the CSD shift-add sequencer, bound to the top level.
// -----------------------------------------------------------------------------
module csd_sas_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [csd_sas_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                               rsp_tlast
);
   import csd_sas_pkg::*;

   // a stalled command holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("command changed while stalled");

   // a request transaction starts a run, so no second request right after it
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a run is starting");

   // a run is not done until its last command leaves
   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |-> !req_tready)
      else $error("request channel open in the middle of a run");

   // reset leaves an empty output and an open request channel
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind csd_shift_add_sequencer csd_sas_checker u_csd_sas_checker (.*);
